// File: hw/rtl/srs_pkg.sv
package srs_pkg;

  // default channel count
  localparam int unsigned NUM_CHANNELS_DEF = 2;

  // register reset values
  localparam logic [15:0] CONF_DIST_RST = 16'd20480;
  localparam logic [7:0]  INV_LIMIT_RST = 8'd5;
  localparam logic [15:0] SMOOTH_W_RST  = 16'd9830;

  // fixed-point constants: Q1.15 one, outlier weight 0.02, jump of 0.5 m in Q4.12
  localparam logic [15:0] ONE_Q15      = 16'd32768;
  localparam logic [15:0] OUTLIER_W    = 16'd655;
  localparam logic [15:0] OUTLIER_JUMP = 16'd2048;

  localparam int unsigned CFG_IDX_W = 2;

  // register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CONF_DIST = 2'd0,
    REG_INV_LIMIT = 2'd1,
    REG_SMOOTH_W  = 2'd2
  } srs_reg_e;

  typedef struct packed {
    logic [15:0] conf_dist;
    logic [7:0]  inv_limit;
    logic [15:0] smooth_w;
  } srs_cfg_t;

  // per-channel state word held in memory
  typedef struct packed {
    logic [15:0] last_raw;
    logic [15:0] smoothed;
    logic        output_ok;
    logic [7:0]  bad_run;
  } srs_state_t;

  localparam srs_state_t STATE_RST = '{
    last_raw:  CONF_DIST_RST,
    smoothed:  16'd0,
    output_ok: 1'b0,
    bad_run:   8'd0
  };

  typedef struct packed {
    logic        channel;
    logic        reading_valid;
    logic [15:0] raw_distance;
  } srs_item_t;

  typedef struct packed {
    logic        out_channel;
    logic [15:0] filtered_distance;
    logic        distance_valid;
    logic [7:0]  invalid_run;
  } srs_result_t;

endpackage

// File: hw/rtl/sonar_range_smoother_unit.sv
// each item passes through the update stage register and then the output register
// throughput: one item per cycle unless stalled, set by a single state read-modify-write
// a state update being written back is forwarded to the next item on the same channel
// reset: asynchronous, active low; registers take their reset values and every
// channel reads as its reset state until first written, with no clearing pass
module sonar_range_smoother_unit import srs_pkg::*; #(
  parameter int unsigned NumChannels = NUM_CHANNELS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic                 channel_i,
  input  logic                 reading_valid_i,
  input  logic [15:0]          raw_distance_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 out_channel_o,
  output logic [15:0]          filtered_distance_o,
  output logic                 distance_valid_o,
  output logic [7:0]           invalid_run_o
);

  localparam int unsigned IdxW = (NumChannels > 1) ? $clog2(NumChannels) : 1;

  srs_cfg_t    cfg_q;
  logic        s1_valid_q;
  srs_item_t   s1_item_q;
  logic        fwd_q;
  srs_state_t  fwd_state_q;
  logic        out_valid_q;
  srs_result_t out_result_q;

  logic        out_load;
  logic        s1_adv;
  logic        in_xfer;
  logic [IdxW-1:0] rd_idx;
  logic [IdxW-1:0] wr_idx;
  srs_state_t  mem_rdata;
  srs_state_t  cur_state;
  logic        upd_we;
  srs_state_t  upd_state;
  srs_result_t upd_result;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.conf_dist <= CONF_DIST_RST;
      cfg_q.inv_limit <= INV_LIMIT_RST;
      cfg_q.smooth_w  <= SMOOTH_W_RST;
    end else if (cfg_we_i) begin
      case (srs_reg_e'(cfg_idx_i))
        REG_CONF_DIST: cfg_q.conf_dist <= cfg_wdata_i;
        REG_INV_LIMIT: cfg_q.inv_limit <= cfg_wdata_i[7:0];
        REG_SMOOTH_W:  cfg_q.smooth_w  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // handshake and pipeline advance
  assign out_load   = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && out_load;
  assign in_stall_o = s1_valid_q && !out_load;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // memory addresses, out-of-range channels steered to entry zero
  assign rd_idx = (32'(channel_i) < 32'(NumChannels)) ? IdxW'(channel_i) : '0;
  assign wr_idx = (32'(s1_item_q.channel) < 32'(NumChannels)) ?
                  IdxW'(s1_item_q.channel) : '0;

  srs_state_mem #(
    .Depth (NumChannels),
    .IdxW  (IdxW)
  ) u_state_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (s1_adv && upd_we),
    .waddr_i (wr_idx),
    .wdata_i (upd_state),
    .re_i    (in_xfer),
    .raddr_i (rd_idx),
    .rdata_o (mem_rdata)
  );

  // forwarded state wins over the stale memory read
  assign cur_state = fwd_q ? fwd_state_q : mem_rdata;

  srs_update #(
    .NumChannels (NumChannels)
  ) u_update (
    .item_i   (s1_item_q),
    .state_i  (cur_state),
    .cfg_i    (cfg_q),
    .we_o     (upd_we),
    .state_o  (upd_state),
    .result_o (upd_result)
  );

  // update stage control and forwarding flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      fwd_q      <= 1'b0;
    end else begin
      if (in_xfer) begin
        s1_valid_q <= 1'b1;
        fwd_q      <= s1_adv && upd_we && (s1_item_q.channel == channel_i);
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  // update stage payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_item_q.channel       <= channel_i;
      s1_item_q.reading_valid <= reading_valid_i;
      s1_item_q.raw_distance  <= raw_distance_i;
      fwd_state_q             <= upd_state;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_result_q <= upd_result;
    end
  end

  assign out_valid_o         = out_valid_q;
  assign out_channel_o       = out_result_q.out_channel;
  assign filtered_distance_o = out_result_q.filtered_distance;
  assign distance_valid_o    = out_result_q.distance_valid;
  assign invalid_run_o       = out_result_q.invalid_run;

endmodule

// File: hw/rtl/srs_state_mem.sv
module srs_state_mem import srs_pkg::*; #(
  parameter int unsigned Depth = NUM_CHANNELS_DEF,
  parameter int unsigned IdxW  = 1
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            we_i,
  input  logic [IdxW-1:0] waddr_i,
  input  srs_state_t      wdata_i,
  input  logic            re_i,
  input  logic [IdxW-1:0] raddr_i,
  output srs_state_t      rdata_o
);

  srs_state_t             mem_q [Depth];
  srs_state_t             rdata_q;
  logic [Depth-1:0]       written_q;
  logic                   rd_written_q;

  // storage write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  // per-entry written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      written_q    <= '0;
      rd_written_q <= 1'b0;
    end else begin
      if (we_i) begin
        written_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rd_written_q <= written_q[raddr_i];
      end
    end
  end

  // entries never written read as the reset state
  assign rdata_o = rd_written_q ? rdata_q : STATE_RST;

endmodule

// File: hw/rtl/srs_update.sv
module srs_update import srs_pkg::*; #(
  parameter int unsigned NumChannels = NUM_CHANNELS_DEF
) (
  input  srs_item_t   item_i,
  input  srs_state_t  state_i,
  input  srs_cfg_t    cfg_i,
  output logic        we_o,
  output srs_state_t  state_o,
  output srs_result_t result_o
);

  logic               in_range;
  logic [15:0]        w_cfg;
  logic [15:0]        w_sel;
  logic [15:0]        diff;
  logic signed [16:0] delta;
  logic signed [33:0] prod;
  logic signed [33:0] acc;
  logic [15:0]        blend_val;
  logic [15:0]        clipped;
  logic [7:0]         bad_inc;

  assign in_range = (32'(item_i.channel) < 32'(NumChannels));

  // weight selection: saturated config weight, outlier weight or one on restart
  always_comb begin
    w_cfg = (cfg_i.smooth_w > ONE_Q15) ? ONE_Q15 : cfg_i.smooth_w;
    diff  = (item_i.raw_distance > state_i.smoothed) ?
            (item_i.raw_distance - state_i.smoothed) :
            (state_i.smoothed - item_i.raw_distance);
    if (!state_i.output_ok) begin
      w_sel = ONE_Q15;
    end else if (diff > OUTLIER_JUMP) begin
      w_sel = OUTLIER_W;
    end else begin
      w_sel = w_cfg;
    end
  end

  // blend as prev + w * (raw - prev), one multiplier, then clip
  always_comb begin
    delta     = $signed({1'b0, item_i.raw_distance}) - $signed({1'b0, state_i.smoothed});
    prod      = $signed({18'd0, w_sel}) * 34'(delta);
    acc       = $signed({3'd0, state_i.smoothed, 15'd0}) + prod;
    blend_val = acc[30:15];
    clipped   = (blend_val >= cfg_i.conf_dist) ? cfg_i.conf_dist : blend_val;
    bad_inc   = (state_i.bad_run == 8'hFF) ? state_i.bad_run : state_i.bad_run + 8'd1;
  end

  // next channel state
  always_comb begin
    state_o = state_i;
    we_o    = in_range;
    if (item_i.reading_valid) begin
      state_o.bad_run = 8'd0;
      if (state_i.last_raw != item_i.raw_distance) begin
        state_o.smoothed  = clipped;
        state_o.output_ok = 1'b1;
        state_o.last_raw  = item_i.raw_distance;
      end
    end else begin
      state_o.bad_run = bad_inc;
      if (bad_inc > cfg_i.inv_limit) begin
        state_o.output_ok = 1'b0;
      end
    end
  end

  // result, its payload zeroed for a channel beyond the range
  always_comb begin
    result_o.out_channel = item_i.channel;
    if (in_range) begin
      result_o.filtered_distance = state_o.smoothed;
      result_o.distance_valid    = state_o.output_ok;
      result_o.invalid_run       = state_o.bad_run;
    end else begin
      result_o.filtered_distance = 16'd0;
      result_o.distance_valid    = 1'b0;
      result_o.invalid_run       = 8'd0;
    end
  end

endmodule

// File: tb/sv/sonar_range_smoother_unit_test.sv
`timescale 1ns / 100ps

module sonar_range_smoother_unit_test;
  import srs_pkg::*;

  localparam int unsigned RESULT_LATENCY = 2;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned NUM_DIRECTED   = 20;
  localparam int unsigned REPORT_LIMIT   = 10;
  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_IDX = 2'd3;

  typedef struct packed {
    srs_item_t   item;
    logic        typed;
    srs_result_t res;
  } reading_row_t;

  localparam srs_result_t NO_RES = '0;

  // directed readings under reset settings; typed rows carry a hand-worked result
  localparam reading_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
    '{'{1'b0, 1'b1, 16'd0},     1'b1, '{1'b0, 16'd0,     1'b1, 8'd0}},
    '{'{1'b1, 1'b1, 16'd65535}, 1'b1, '{1'b1, 16'd20480, 1'b1, 8'd0}},
    '{'{1'b0, 1'b1, 16'd0},     1'b1, '{1'b0, 16'd0,     1'b1, 8'd0}},
    '{'{1'b0, 1'b0, 16'd65535}, 1'b1, '{1'b0, 16'd0,     1'b1, 8'd1}},
    '{'{1'b0, 1'b0, 16'd0},     1'b0, NO_RES},
    '{'{1'b0, 1'b0, 16'd12345}, 1'b0, NO_RES},
    '{'{1'b0, 1'b0, 16'd0},     1'b0, NO_RES},
    '{'{1'b0, 1'b0, 16'd0},     1'b1, '{1'b0, 16'd0,     1'b1, 8'd5}},
    '{'{1'b0, 1'b0, 16'd0},     1'b1, '{1'b0, 16'd0,     1'b0, 8'd6}},
    '{'{1'b0, 1'b1, 16'd0},     1'b1, '{1'b0, 16'd0,     1'b0, 8'd0}},
    '{'{1'b0, 1'b1, 16'd4096},  1'b1, '{1'b0, 16'd4096,  1'b1, 8'd0}},
    '{'{1'b0, 1'b1, 16'd6144},  1'b0, NO_RES},
    '{'{1'b0, 1'b1, 16'd6759},  1'b0, NO_RES},
    '{'{1'b0, 1'b1, 16'd65535}, 1'b0, NO_RES},
    '{'{1'b0, 1'b1, 16'd0},     1'b0, NO_RES},
    '{'{1'b1, 1'b1, 16'd20480}, 1'b0, NO_RES},
    '{'{1'b1, 1'b0, 16'd0},     1'b0, NO_RES},
    '{'{1'b1, 1'b1, 16'd20480}, 1'b0, NO_RES},
    '{'{1'b1, 1'b1, 16'd32768}, 1'b0, NO_RES},
    '{'{1'b0, 1'b1, 16'd1},     1'b0, NO_RES}
  };

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic                 channel_i;
  logic                 reading_valid_i;
  logic [15:0]          raw_distance_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 out_channel_o;
  logic [15:0]          filtered_distance_o;
  logic                 distance_valid_o;
  logic [7:0]           invalid_run_o;

  // settings as the block should hold them
  logic [15:0] conf_dist_set;
  logic [7:0]  inv_limit_set;
  logic [15:0] smooth_w_set;

  // per-channel filter state as the block should hold it
  logic [15:0] last_reading  [NUM_CHANNELS_DEF];
  logic [15:0] smoothed_dist [NUM_CHANNELS_DEF];
  logic        dist_ok       [NUM_CHANNELS_DEF];
  logic [7:0]  bad_count     [NUM_CHANNELS_DEF];

  srs_result_t pending_results [$];
  srs_result_t want;
  int unsigned fail_count;
  int unsigned idle_cycles;
  logic        no_idle;

  sonar_range_smoother_unit dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .channel_i           (channel_i),
    .reading_valid_i     (reading_valid_i),
    .raw_distance_i      (raw_distance_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .out_channel_o       (out_channel_o),
    .filtered_distance_o (filtered_distance_o),
    .distance_valid_o    (distance_valid_o),
    .invalid_run_o       (invalid_run_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // advance one channel's filter by one reading and return what the block should report
  function automatic srs_result_t smooth_reading(srs_item_t it);
    srs_result_t r;
    logic [16:0] w;
    logic [15:0] prev;
    logic [15:0] diff;
    logic [32:0] acc;
    logic [32:0] blended;
    int unsigned c;
    c = 32'(it.channel);
    if (it.reading_valid) begin
      bad_count[c] = 8'd0;
      if (last_reading[c] != it.raw_distance) begin
        prev = smoothed_dist[c];
        w = (smooth_w_set > ONE_Q15) ? 17'(ONE_Q15) : 17'(smooth_w_set);
        diff = (it.raw_distance > prev) ? it.raw_distance - prev : prev - it.raw_distance;
        // an invalid output restarts the filter from the raw reading
        if (!dist_ok[c]) begin
          dist_ok[c] = 1'b1;
          w = 17'(ONE_Q15);
        end else if (diff > OUTLIER_JUMP) begin
          w = 17'(OUTLIER_W);
        end
        acc = 33'(w) * 33'(it.raw_distance) + (33'(ONE_Q15) - 33'(w)) * 33'(prev);
        blended = acc >> 15;
        if (blended >= 33'(conf_dist_set)) blended = 33'(conf_dist_set);
        smoothed_dist[c] = blended[15:0];
        last_reading[c] = it.raw_distance;
      end
    end else begin
      if (bad_count[c] != 8'd255) bad_count[c] = bad_count[c] + 8'd1;
      if (bad_count[c] > inv_limit_set) dist_ok[c] = 1'b0;
    end
    r.out_channel       = it.channel;
    r.filtered_distance = smoothed_dist[c];
    r.distance_valid    = dist_ok[c];
    r.invalid_run       = bad_count[c];
    return r;
  endfunction

  // raw distance biased towards repeats, small steps and the outlier boundary
  function automatic logic [15:0] pick_raw(logic ch);
    logic [15:0] base;
    logic [15:0] step;
    logic [15:0] nudge;
    base  = smoothed_dist[ch];
    step  = 16'($urandom_range(0, 4096));
    nudge = 16'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1:    return last_reading[ch];
      2, 3, 4: return base + step - 16'd2048;
      5:       return ($urandom_range(0, 1) != 0) ? base + OUTLIER_JUMP + nudge
                                                  : base - OUTLIER_JUMP - nudge;
      6: begin
        case ($urandom_range(0, 2))
          0:       return 16'd0;
          1:       return 16'hFFFF;
          default: return conf_dist_set;
        endcase
      end
      default: return 16'($urandom);
    endcase
  endfunction

  // one reading transfer: optional gap, hold until taken, then record the expectation
  task automatic send_reading(srs_item_t it, logic typed, srs_result_t typed_res);
    int unsigned gap;
    srs_result_t predicted;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    channel_i       <= it.channel;
    reading_valid_i <= it.reading_valid;
    raw_distance_i  <= it.raw_distance;
    do @(posedge clk_i); while (in_stall_o);
    predicted = smooth_reading(it);
    pending_results.push_back(typed ? typed_res : predicted);
  endtask

  // stop sending and wait until every result is back
  task automatic settle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (RESULT_LATENCY + 1) @(posedge clk_i);
  endtask

  // write all three registers plus the spare index in one burst
  task automatic apply_settings(logic [15:0] conf, logic [15:0] limit, logic [15:0] weight);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_CONF_DIST;
    cfg_wdata_i <= conf;
    @(posedge clk_i);
    cfg_idx_i   <= REG_INV_LIMIT;
    cfg_wdata_i <= limit;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SMOOTH_W;
    cfg_wdata_i <= weight;
    @(posedge clk_i);
    cfg_idx_i   <= REG_SPARE_IDX;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    conf_dist_set = conf;
    inv_limit_set = limit[7:0];
    smooth_w_set  = weight;
  endtask

  // random readings, mostly valid, with bursts of back-to-back traffic
  task automatic run_readings(int unsigned count);
    srs_item_t it;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      it.channel       = 1'($urandom_range(0, 1));
      it.reading_valid = ($urandom_range(0, 9) < 7);
      it.raw_distance  = pick_raw(it.channel);
      send_reading(it, 1'b0, NO_RES);
    end
    no_idle = 1'b0;
    settle();
  endtask

  // stimulus
  initial begin
    srs_item_t it;
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = REG_CONF_DIST;
    cfg_wdata_i     = 16'd0;
    in_valid_i      = 1'b0;
    channel_i       = 1'b0;
    reading_valid_i = 1'b0;
    raw_distance_i  = 16'd0;
    no_idle         = 1'b0;
    fail_count      = 0;
    conf_dist_set   = CONF_DIST_RST;
    inv_limit_set   = INV_LIMIT_RST;
    smooth_w_set    = SMOOTH_W_RST;
    for (int c = 0; c < NUM_CHANNELS_DEF; c++) begin
      last_reading[c]  = STATE_RST.last_raw;
      smoothed_dist[c] = STATE_RST.smoothed;
      dist_ok[c]       = STATE_RST.output_ok;
      bad_count[c]     = STATE_RST.bad_run;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed rows under reset settings
    for (int unsigned r = 0; r < NUM_DIRECTED; r++)
      send_reading(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].res);
    settle();
    run_readings(40);

    // widest ceiling, no tolerance, full weight
    apply_settings(16'hFFFF, 16'd0, ONE_Q15);
    run_readings(40);

    // zero ceiling and weight, largest tolerance; long invalid run saturates the count
    apply_settings(16'd0, 16'hFFFF, 16'd0);
    run_readings(30);
    it.channel       = 1'b0;
    it.reading_valid = 1'b1;
    it.raw_distance  = 16'($urandom);
    send_reading(it, 1'b0, NO_RES);
    for (int unsigned i = 0; i < 258; i++) begin
      it.reading_valid = 1'b0;
      it.raw_distance  = 16'($urandom);
      send_reading(it, 1'b0, NO_RES);
    end
    settle();

    // weight above one is clamped; limit taken from the low byte only
    apply_settings(16'($urandom_range(2048, 65535)), 16'hA502, 16'hFFFF);
    run_readings(40);

    // random mid-range settings
    repeat (2) begin
      apply_settings(16'($urandom_range(4096, 65535)), 16'($urandom_range(0, 8)),
                     16'($urandom_range(0, 32768)));
      run_readings(30);
    end

    if (pending_results.size() != 0) fail_count++;
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    int unsigned hold;
    out_stall_i = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 8);
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  // compare each result transfer against the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        if (fail_count < REPORT_LIMIT)
          $display("unexpected result: ch %0d dist %0d ok %0d run %0d", out_channel_o,
                   filtered_distance_o, distance_valid_o, invalid_run_o);
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_channel_o !== want.out_channel ||
            filtered_distance_o !== want.filtered_distance ||
            distance_valid_o !== want.distance_valid ||
            invalid_run_o !== want.invalid_run) begin
          if (fail_count < REPORT_LIMIT)
            $display({"mismatch: expected ch %0d dist %0d ok %0d run %0d, ",
                      "got ch %0d dist %0d ok %0d run %0d"},
                     want.out_channel, want.filtered_distance, want.distance_valid,
                     want.invalid_run, out_channel_o, filtered_distance_o,
                     distance_valid_o, invalid_run_o);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles = idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  initial idle_cycles = 0;

endmodule
